[sv/mrrb_pkg.sv]
package mrrb_pkg;

    // Storage geometry
    localparam int DEPTH      = 16;
    localparam int CONSUMERS  = 4;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);

    // Field widths fixed by the interface
    localparam int OPCODE_W   = 1;
    localparam int CONSUMER_W = 2;
    localparam int WORD_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int CAP_W      = 5;
    localparam int ACT_W      = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_WRITE = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_READ  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE   = 1'd1;

    // Reset values of the configuration registers
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;
    localparam logic [ACT_W-1:0] ACTIVE_RESET   = 3'd4;

    typedef logic [OPCODE_W-1:0]   opcode_t;
    typedef logic [CONSUMER_W-1:0] consumer_t;
    typedef logic [WORD_W-1:0]     word_t;
    typedef logic [STATUS_W-1:0]   status_t;
    typedef logic [ADDR_W-1:0]     addr_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the accepted transaction
        logic exec;      // evaluate and update heads / store
        logic grab;      // take read data from the ring memory
        logic publish;   // move result into the output register
    } mrrb_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic read_go;   // evaluated transaction is a granted read
        logic out_free;  // output register can take a new result
    } mrrb_stat_t;

endpackage

[sv/mrrb_ifs.sv]
interface mrrb_in_if;
    import mrrb_pkg::*;

    logic      valid;
    logic      ready;
    opcode_t   opcode;
    consumer_t consumer;
    word_t     write_data;

    modport source (output valid, output opcode, output consumer, output write_data,
                    input ready);
    modport sink   (input valid, input opcode, input consumer, input write_data,
                    output ready);
endinterface

interface mrrb_out_if;
    import mrrb_pkg::*;

    logic    valid;
    logic    ready;
    word_t   read_data;
    status_t status;

    modport source (output valid, output read_data, output status, input ready);
    modport sink   (input valid, input read_data, input status, output ready);
endinterface

[sv/mrrb_ram.sv]
module mrrb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/mrrb_ctrl.sv]
module mrrb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mrrb_pkg::mrrb_stat_t stat,
    output mrrb_pkg::mrrb_cmd_t  cmd
);
    import mrrb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EVAL   = 4'b0010,
        S_RDWAIT = 4'b0100,
        S_DONE   = 4'b1000
    } mrrb_state_t;

    mrrb_state_t state_reg;
    mrrb_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.read_go ? S_RDWAIT : S_DONE;
            end
            S_RDWAIT:
            begin
                cmd.grab   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

[sv/mrrb_dp.sv]
module mrrb_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mrrb_pkg::opcode_t                   opcode,
    input  mrrb_pkg::consumer_t                 consumer,
    input  mrrb_pkg::word_t                     write_data,
    input  logic                                cfg_wr_en,
    input  logic [mrrb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mrrb_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  mrrb_pkg::mrrb_cmd_t                 cmd,
    output mrrb_pkg::mrrb_stat_t                stat,
    mrrb_out_if.source                          reply
);
    import mrrb_pkg::*;

    // Configuration
    logic [CAP_W-1:0] capacity_reg;
    logic [ACT_W-1:0] active_consumers_reg;

    // Heads
    addr_t wp_reg;
    addr_t rp_reg [CONSUMERS];

    // Captured transaction
    opcode_t   op_reg;
    consumer_t who_reg;
    word_t     wdata_reg;

    // Pending result and output register
    word_t   res_data_reg;
    status_t res_status_reg;
    word_t   out_data_reg;
    status_t out_status_reg;
    logic    out_valid_reg;

    logic [CAP_W-1:0]  eff_cap;
    logic [ACT_W-1:0]  eff_act;
    addr_t             wp_adv;
    addr_t             rp_sel;
    addr_t             rp_adv;
    logic [ADDR_W:0]   wp_inc;
    logic [ADDR_W:0]   rp_inc;
    logic              full;
    logic              who_bad;
    logic              empty;
    logic              wr_ok;
    logic              rd_ok;
    status_t           status_eval;
    logic [DATA_WIDTH-1:0] ram_rdata;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg         <= CAPACITY_RESET;
            active_consumers_reg <= ACTIVE_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_CAPACITY: capacity_reg         <= CAP_W'(cfg_wdata);
                REG_ACTIVE:   active_consumers_reg <= ACT_W'(cfg_wdata);
                default:      ;
            endcase
        end
    end

    // Clamp configuration to legal ranges
    always_comb
    begin
        if (capacity_reg < CAP_W'(2))
            eff_cap = CAP_W'(2);
        else if (32'(capacity_reg) > DEPTH)
            eff_cap = CAP_W'(DEPTH);
        else
            eff_cap = capacity_reg;

        if (active_consumers_reg < ACT_W'(1))
            eff_act = ACT_W'(1);
        else if (32'(active_consumers_reg) > CONSUMERS)
            eff_act = ACT_W'(CONSUMERS);
        else
            eff_act = active_consumers_reg;
    end

    // Head advance with wrap at capacity
    assign wp_inc = {1'b0, wp_reg} + (ADDR_W+1)'(1);
    assign wp_adv = (32'(wp_inc) >= 32'(eff_cap)) ? '0 : wp_inc[ADDR_W-1:0];
    assign rp_sel = rp_reg[who_reg[$clog2(CONSUMERS > 1 ? CONSUMERS : 2)-1:0]];
    assign rp_inc = {1'b0, rp_sel} + (ADDR_W+1)'(1);
    assign rp_adv = (32'(rp_inc) >= 32'(eff_cap)) ? '0 : rp_inc[ADDR_W-1:0];

    // Full: next write head meets any active read head
    always_comb
    begin
        full = 1'b0;
        for (int c = 0; c < CONSUMERS; c++)
        begin
            if ((c < 32'(eff_act)) && (rp_reg[c] == wp_adv))
                full = 1'b1;
        end
    end

    // Empty: inactive consumer, or its head meets the write head
    assign who_bad = (32'(who_reg) >= 32'(eff_act)) || (32'(who_reg) >= CONSUMERS);
    assign empty   = who_bad || (rp_sel == wp_reg);
    assign wr_ok   = (op_reg == OP_WRITE) && !full;
    assign rd_ok   = (op_reg == OP_READ) && !empty;

    always_comb
    begin
        if (op_reg == OP_WRITE)
            status_eval = full ? STATUS_FULL : STATUS_DONE;
        else
            status_eval = empty ? STATUS_EMPTY : STATUS_DONE;
    end

    // Transaction capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= opcode;
            who_reg   <= consumer;
            wdata_reg <= write_data;
        end
    end

    // Head updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            for (int c = 0; c < CONSUMERS; c++)
                rp_reg[c] <= '0;
        end
        else if (cmd.exec)
        begin
            if (wr_ok)
                wp_reg <= wp_adv;
            if (rd_ok)
                rp_reg[who_reg[$clog2(CONSUMERS > 1 ? CONSUMERS : 2)-1:0]] <= rp_adv;
        end
    end

    // Ring memory
    mrrb_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.exec && wr_ok),
        .waddr (wp_reg),
        .wdata (DATA_WIDTH'(wdata_reg)),
        .raddr (rp_sel),
        .rdata (ram_rdata)
    );

    // Pending result
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_status_reg <= status_eval;
            res_data_reg   <= '0;
        end
        else if (cmd.grab)
        begin
            res_data_reg <= WORD_W'(ram_rdata);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.publish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (reply.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            out_data_reg   <= res_data_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign stat.read_go  = rd_ok;
    assign stat.out_free = !out_valid_reg || reply.ready;

    assign reply.valid     = out_valid_reg;
    assign reply.read_data = out_data_reg;
    assign reply.status    = out_status_reg;

endmodule

[sv/multi_reader_ring_buffer.sv]
// Broadcast ring buffer with one write head and a read head per consumer; every
// active consumer sees every written word in order. An access transaction on
// "access" is a write (opcode 0) or a read for one consumer (opcode 1); each
// gives exactly one result on "reply": status 0 done, 1 write refused as full
// (the next write slot is some active consumer's head), 2 read refused as empty
// (consumer inactive or caught up with the writer). read_data carries the word
// of a granted read and is zero otherwise. A write or a refused access moves from
// the evaluate state through the done state into the output register; a granted
// read also passes a read-wait state for the registered read of the ring memory.
// The next transaction is accepted in the cycle after the result moves into the
// output register. The output register holds a result until taken.
// Configuration (capacity 2..16, active consumers 1..4, out-of-range values
// clamped) is to be written through cfg_wr_en / cfg_index / cfg_wdata only
// while the block is idle; the block itself does not enforce this. Reading a
// slot never written returns undefined data.
module multi_reader_ring_buffer (
    input  logic                              clk,
    input  logic                              rst_n,
    mrrb_in_if.sink                           access,
    mrrb_out_if.source                        reply,
    input  logic                              cfg_wr_en,
    input  logic [mrrb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mrrb_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import mrrb_pkg::*;

    mrrb_cmd_t  cmd;
    mrrb_stat_t stat;
    logic       in_ready;

    assign access.ready = in_ready;

    // Sequencer
    mrrb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (access.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Heads, ring memory and result registers
    mrrb_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .opcode     (access.opcode),
        .consumer   (access.consumer),
        .write_data (access.write_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .cmd        (cmd),
        .stat       (stat),
        .reply      (reply)
    );

endmodule
